/* hw/rtl/stng_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the note generator.
package stng_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int COUNT_BITS      = 20;

    localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;

    localparam int STEP_W     = 31;
    localparam int NOTE_W     = 20;
    localparam int AMP_W      = 15;
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 32;
    localparam int SINE_W     = 17;
    localparam int PROD_W     = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(24576);

    // Tick queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        CMD_NOTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // One sample to be rendered by the back.
    typedef struct packed {
        logic [TABLE_ADDR_BITS-1:0] addr;
        logic                       rest;
        logic                       last;
    } t_tick;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_status;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // Reciprocals of the Taylor divisors (2k)(2k+1): floor(n / d) equals
    // (n * R) >> RECIP_SHIFT for any 64-bit n and any divisor up to 1024.
    localparam int          RECIP_SHIFT = 74;
    localparam logic [79:0] RECIP_ONE   = 80'd1 << RECIP_SHIFT;
    localparam logic [79:0] TAYLOR_RECIP [1:15] = '{
        (RECIP_ONE + 80'd5)   / 80'd6,
        (RECIP_ONE + 80'd19)  / 80'd20,
        (RECIP_ONE + 80'd41)  / 80'd42,
        (RECIP_ONE + 80'd71)  / 80'd72,
        (RECIP_ONE + 80'd109) / 80'd110,
        (RECIP_ONE + 80'd155) / 80'd156,
        (RECIP_ONE + 80'd209) / 80'd210,
        (RECIP_ONE + 80'd271) / 80'd272,
        (RECIP_ONE + 80'd341) / 80'd342,
        (RECIP_ONE + 80'd419) / 80'd420,
        (RECIP_ONE + 80'd505) / 80'd506,
        (RECIP_ONE + 80'd599) / 80'd600,
        (RECIP_ONE + 80'd701) / 80'd702,
        (RECIP_ONE + 80'd811) / 80'd812,
        (RECIP_ONE + 80'd929) / 80'd930
    };

    typedef logic [AMP_W-1:0] t_qtr_table [QTR_SIZE+1];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(32767 * sin(pi/2 * q / QTR_SIZE)) in exact fixed point (Q62 Taylor series)
    function automatic logic [AMP_W-1:0] quarter_sine(input int q);
        logic [127:0] p;
        logic [143:0] w;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [31:0]  v;
        p    = {64'd0, HALF_PI_Q62} * 128'(q);
        x    = p[QTR_BITS +: 64];
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 15; k++) begin
            w    = 144'(mul_q62(term, x2)) * 144'(TAYLOR_RECIP[k]);
            term = w[RECIP_SHIFT +: 64];
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        p = {64'd0, sum} * 128'd32767 + (128'd1 << 61);
        v = p[62 +: 32];
        if ($signed(v) > 32767) begin
            v = 32'd32767;
        end
        return v[AMP_W-1:0];
    endfunction

    function automatic t_qtr_table build_qtr_table();
        t_qtr_table t;
        for (int q = 0; q <= QTR_SIZE; q++) begin
            t[q] = quarter_sine(q);
        end
        return t;
    endfunction

    localparam t_qtr_table QTR_TABLE = build_qtr_table();

endpackage

/* hw/rtl/sine_tone_note_generator.sv */
// Top level of the sine tone note generator (direct digital synthesis oscillator).
//
// Input stream (s_axis): tuser carries the command, 0 starts a note, 1 asks for
// one sample. tdata holds tone_step in bits 30:0 and note_samples in 50:31.
// A note clears the phase, loads step and sample count, and gives no output.
// Each tick while samples remain gives one output transfer; extra ticks vanish.
// Output stream (m_axis): tdata holds the signed mono sample in 15:0 and the
// stereo frame (left in 31:16, right in 47:32); tlast marks a note's last sample.
// Rate: one input transfer per cycle while the tick queue is not full. An
// accepted tick reaches m_axis via the queue head, table lookup, multiply and
// output register. A four-entry tick queue sits between the command front
// and the render pipeline; s_axis_tready falls only when that queue is full.
// When the receiver stalls, the output register holds its transfer and the
// pipeline stages fill before the queue starts to back up.
// Reset (synchronous, active low) clears phase, step and count, empties the
// queue and pipeline, and sets the gain to 24576 (0.75 of full scale).
// The gain register takes i_cfg_wdata at any edge with i_cfg_we high; write it
// only while no samples are in flight.
module sine_tone_note_generator
    import stng_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [AMP_W-1:0]      i_cfg_wdata,       // amplitude, Q0.15
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,    // tone_step[30:0], note_samples[50:31]
    input  logic                  i_s_axis_tuser,    // cmd
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,    // sample[15:0], frame_word[47:16]
    output logic                  o_m_axis_tlast     // last_of_note
);

    logic [AMP_W-1:0] r_amplitude;
    logic             q_push;
    logic             q_pop;
    t_tick            q_in;
    t_tick            q_head;
    t_q_status        q_status;
    t_cmd             cmd;

    assign cmd = t_cmd'(i_s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude <= AMP_RESET;
        end else if (i_cfg_we) begin
            r_amplitude <= i_cfg_wdata;
        end
    end

    stng_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .i_cmd          (cmd),
        .i_tone_step    (i_s_axis_tdata[STEP_W-1:0]),
        .i_note_samples (i_s_axis_tdata[STEP_W +: NOTE_W]),
        .i_q_status     (q_status),
        .o_ready        (o_s_axis_tready),
        .o_push         (q_push),
        .o_tick         (q_in)
    );

    stng_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_tick   (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    stng_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_amplitude (r_amplitude),
        .i_q_status  (q_status),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .o_data      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .i_ready     (i_m_axis_tready)
    );

    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_status.full))
        else $error("tick queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && !q_status.avail))
        else $error("tick queue underflow");

    // Left and right channels and the mono sample always agree.
    a_stereo_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[47:32] == o_m_axis_tdata[15:0]) &&
                            (o_m_axis_tdata[31:16] == o_m_axis_tdata[15:0]))
        else $error("stereo frame does not match sample");

    // Output valid is low when reset has just been released.
    a_empty_after_reset: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

/* hw/rtl/stng_front.sv */
// Front: takes commands, holds note state and queues one tick per sample due.
module stng_front
    import stng_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cmd              i_cmd,
    input  logic [STEP_W-1:0] i_tone_step,
    input  logic [NOTE_W-1:0] i_note_samples,
    input  t_q_status         i_q_status,
    output logic              o_ready,
    output logic              o_push,
    output t_tick             o_tick
);

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [STEP_W-1:0]     r_step,  n_step;
    logic [COUNT_BITS-1:0] r_left,  n_left;
    logic                  accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase     = r_phase;
        n_step      = r_step;
        n_left      = r_left;
        o_push      = 1'b0;
        o_tick.addr = r_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS];
        o_tick.rest = (r_step == '0);
        o_tick.last = (r_left == COUNT_BITS'(1));
        if (accept) begin
            unique case (i_cmd)
                CMD_NOTE: begin
                    n_phase = '0;
                    n_step  = i_tone_step;
                    n_left  = COUNT_BITS'(i_note_samples);
                end
                CMD_TICK: begin
                    // drop ticks once the note has run out
                    if (r_left != '0) begin
                        o_push  = 1'b1;
                        n_phase = r_phase + PHASE_BITS'(r_step);
                        n_left  = r_left - COUNT_BITS'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= '0;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_left  <= n_left;
        end
    end

endmodule

/* hw/rtl/stng_queue.sv */
// Short tick queue that decouples the front from the back.
module stng_queue
    import stng_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_tick     i_tick,
    input  logic      i_pop,
    output t_tick     o_head,
    output t_q_status o_status
);

    t_tick              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.avail  = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/stng_back.sv */
// Back: sine lookup, gain multiply and output register with stall handling.
module stng_back
    import stng_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [AMP_W-1:0]      i_amplitude,
    input  t_q_status             i_q_status,
    input  t_tick                 i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_last,
    input  logic                  i_ready
);

    logic                     r_s1_valid;
    logic signed [SINE_W-1:0] r_s1_sine;
    logic                     r_s1_last;
    logic                     r_s2_valid;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_s2_last;
    logic                     r_o_valid;

    logic                     out_ready;
    logic                     s2_ready;
    logic                     s1_ready;
    logic [1:0]               quad;
    logic [QTR_BITS-1:0]      rem;
    logic [QTR_BITS:0]        qidx;
    logic [AMP_W-1:0]         mag;
    logic signed [SINE_W-1:0] sine;
    logic signed [PROD_W-1:0] prod_adj;
    logic [SAMPLE_W-1:0]      sample;

    assign out_ready = !r_o_valid || i_ready;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign o_pop     = i_q_status.avail && s1_ready;

    // Fold the full cycle onto the quarter wave; a rest reads as silence.
    always_comb begin
        quad = i_head.addr[TABLE_ADDR_BITS-1 -: 2];
        rem  = i_head.addr[QTR_BITS-1:0];
        qidx = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, rem}) : {1'b0, rem};
        mag  = QTR_TABLE[qidx];
        sine = quad[1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        if (i_head.rest) begin
            sine = '0;
        end
    end

    // Truncate toward zero when dropping the Q0.15 fraction.
    assign prod_adj = r_s2_prod + (r_s2_prod[PROD_W-1] ? PROD_W'(32767) : '0);
    assign sample   = SAMPLE_W'(prod_adj >>> AMP_W);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_sine <= sine;
            r_s1_last <= i_head.last;
        end
        if (r_s1_valid && s2_ready) begin
            r_s2_prod <= $signed({1'b0, i_amplitude}) * r_s1_sine;
            r_s2_last <= r_s1_last;
        end
        if (r_s2_valid && out_ready) begin
            o_data <= {sample, sample, sample};
            o_last <= r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= o_pop;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    assign o_valid = r_o_valid;

endmodule
